### rtl/msi_dir_pkg.sv
// shared types, constants and codes of the two-core msi coherence directory
`default_nettype none
package msi_dir_pkg;

   // directory geometry
   localparam int WORDS  = 256;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int DATA_W = 32;
   localparam int LINE_W = DATA_W + 4;

   // bus operation codes
   typedef enum logic [1:0] {
      OP_UPGRADE    = 2'd0,
      OP_BUS_READ   = 2'd1,
      OP_READ_EXCL  = 2'd2,
      OP_WRITE_BACK = 2'd3
   } op_type;

   // per-core msi state codes
   localparam logic [1:0] ST_I = 2'd0;
   localparam logic [1:0] ST_S = 2'd1;
   localparam logic [1:0] ST_M = 2'd2;

   // one directory entry: value and both cores' states (core 0 in bits 1..0)
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [3:0]        states;
   } line_type;

   // one bus request as held in the pipeline
   typedef struct packed {
      op_type            op;
      logic              requester;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] write_data;
      logic [DATA_W-1:0] flush_data;
      logic              peer_active;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              peer_flushed;
      logic              peer_invalidated;
      logic [1:0]        requester_state;
      logic [1:0]        peer_state;
   } rsp_item_type;

endpackage
`default_nettype wire

### rtl/msi_two_core_coherence_directory.sv
// top level of the two-core msi coherence directory
//
// Usage: each item on the req_ channel is one bus request from one of two
// cores (op and requester in req_tuser; address, write-back value, the
// peer's flush value and the peer-active flag in req_tdata). For every item
// exactly one item leaves on the rsp_ channel, in order: the word's value
// after the request, the flush and invalidate flags and both new states.
// Throughput: one item per cycle while the receiver takes results; the
// entry is read from the directory ram at acceptance and written back as
// its result enters the output register, and a request to the entry being
// written in that cycle takes the new contents through a forwarding
// register. Entries start as value zero with both cores invalid; one valid
// flip-flop per entry, cleared by reset, stands for that, so the block is
// ready as soon as reset ends. When the receiver stalls, the result waits
// in the output register, one more request is taken into the work stage,
// and then req_tready drops.
`default_nettype none
module msi_two_core_coherence_directory
   import msi_dir_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // word_address[7:0], write_data[39:8], peer_flush_data[71:40], peer_active[72]
   input  wire logic [79:0] req_tdata,
   // op[1:0], requester[2]
   input  wire logic [2:0]  req_tuser,
   // result item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], peer_flushed[32], peer_invalidated[33],
   // requester_state[35:34], peer_state[37:36]
   output logic [39:0]      rsp_tdata
);

   req_item_type  in_item;
   logic          accept;
   logic          advance;

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   logic          entry_valid_ff [WORDS];
   logic          rd_valid_ff;
   logic          fwd_ff, fwd_in;
   line_type      fwd_line_ff;
   line_type      ram_rd;
   line_type      line_old;
   line_type      line_new;
   rsp_item_type  result;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   logic          wr_en;

   // unpack the request
   assign in_item.op          = op_type'(req_tuser[1:0]);
   assign in_item.requester   = req_tuser[2];
   assign in_item.addr        = req_tdata[ADDR_W-1:0];
   assign in_item.write_data  = req_tdata[39:8];
   assign in_item.flush_data  = req_tdata[71:40];
   assign in_item.peer_active = req_tdata[72];

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = s1_valid_ff && advance;

   // directory ram: value and both states of each word
   msi_ram #(
      .WIDTH (LINE_W),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_item_ff.addr),
      .wr_data (line_new),
      .rd_en   (accept),
      .rd_addr (in_item.addr),
      .rd_data (ram_rd)
   );

   // entry as seen by the work stage: forwarded, stored or reset value
   always_comb begin
      priority if (fwd_ff) begin
         line_old = fwd_line_ff;
      end else if (rd_valid_ff) begin
         line_old = ram_rd;
      end else begin
         line_old = '0;
      end
   end

   msi_dir_next u_next (
      .item     (s1_item_ff),
      .line_old (line_old),
      .line_new (line_new),
      .result   (result)
   );

   // next-state of the pipeline control
   assign fwd_in      = wr_en && (s1_item_ff.addr == in_item.addr);
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WORDS; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            entry_valid_ff[s1_item_ff.addr] <= 1'b1;
         end
      end
   end

   // payload registers of the work stage and the output
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= in_item;
         rd_valid_ff <= entry_valid_ff[in_item.addr];
         fwd_ff      <= fwd_in;
         fwd_line_ff <= line_new;
      end
      if (wr_en) begin
         rsp_item_ff <= result;
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.peer_state, rsp_item_ff.requester_state,
                        rsp_item_ff.peer_invalidated, rsp_item_ff.peer_flushed,
                        rsp_item_ff.read_data};

endmodule
`default_nettype wire

### rtl/msi_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module msi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port (read returns the old contents)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/msi_dir_next.sv
// msi transition logic: new entry contents and result for one bus request
`default_nettype none
module msi_dir_next
   import msi_dir_pkg::*;
(
   input  wire req_item_type item,
   input  wire line_type     line_old,
   output line_type          line_new,
   output rsp_item_type      result
);

   logic [1:0]        req_old;
   logic [1:0]        peer_old;
   logic [1:0]        req_new;
   logic [1:0]        peer_new;
   logic [DATA_W-1:0] value_new;
   logic              flushed;
   logic              invalidated;

   // pick requester and peer slots of the state field
   assign req_old  = item.requester ? line_old.states[3:2] : line_old.states[1:0];
   assign peer_old = item.requester ? line_old.states[1:0] : line_old.states[3:2];

   // protocol transitions
   always_comb begin
      req_new     = req_old;
      peer_new    = peer_old;
      value_new   = line_old.value;
      flushed     = 1'b0;
      invalidated = 1'b0;
      unique case (item.op)
         OP_UPGRADE: begin
            req_new = ST_M;
            if (item.peer_active) begin
               peer_new    = ST_I;
               invalidated = 1'b1;
            end
         end
         OP_BUS_READ: begin
            if (req_old == ST_I) begin
               req_new = ST_S;
            end
            if (item.peer_active && peer_old == ST_M) begin
               value_new = item.flush_data;
               peer_new  = ST_S;
               flushed   = 1'b1;
            end
         end
         OP_READ_EXCL: begin
            req_new = ST_M;
            if (item.peer_active && peer_old != ST_I) begin
               if (peer_old == ST_M) begin
                  value_new = item.flush_data;
                  flushed   = 1'b1;
               end
               peer_new    = ST_I;
               invalidated = 1'b1;
            end
         end
         OP_WRITE_BACK: begin
            value_new   = item.write_data;
            invalidated = item.peer_active && peer_old != ST_I;
            req_new     = ST_I;
            peer_new    = ST_I;
         end
         default: begin
            req_new = req_old;
         end
      endcase
   end

   // repack entry and result
   assign line_new.value  = value_new;
   assign line_new.states = item.requester ? {req_new, peer_new} : {peer_new, req_new};

   assign result.read_data        = value_new;
   assign result.peer_flushed     = flushed;
   assign result.peer_invalidated = invalidated;
   assign result.requester_state  = req_new;
   assign result.peer_state       = peer_new;

endmodule
`default_nettype wire

### sim/tb_msi_two_core_coherence_directory.sv
// self-checking testbench of the two-core msi coherence directory
`timescale 1ns / 1ps
module tb_msi_two_core_coherence_directory;
   import msi_dir_pkg::*;

   localparam int N_RANDOM    = 400;
   localparam int PAUSE_AT    = 200;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;
   localparam int N_ROWS      = 20;

   // one directed row: request fields, and a typed reply where one is known
   typedef struct packed {
      op_type            op;
      logic              requester;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [DATA_W-1:0] fdata;
      logic              active;
      logic              has_exp;
      rsp_item_type      exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // directory copy kept by the testbench
   logic [DATA_W-1:0] word_store [WORDS];
   logic [1:0]        core_state [WORDS][2];

   rsp_item_type pending_replies [$];
   int           n_errors = 0;
   int           idle_cycles = 0;
   logic         hold_req = 1'b0;

   // directed rows: extremes, every op, inactive peer, flush and invalidate cases
   stim_row_type dir_rows [N_ROWS] = '{
      '{OP_BUS_READ,   1'b0, 8'd0,   32'h0,        32'h0,        1'b1, 1'b1,
        '{32'h0,        1'b0, 1'b0, ST_S, ST_I}},
      '{OP_UPGRADE,    1'b1, 8'd255, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1,
        '{32'h0,        1'b0, 1'b1, ST_M, ST_I}},
      '{OP_BUS_READ,   1'b0, 8'd255, 32'h0,        32'h7fffffff, 1'b1, 1'b1,
        '{32'h7fffffff, 1'b1, 1'b0, ST_S, ST_S}},
      '{OP_READ_EXCL,  1'b1, 8'd255, 32'h0,        32'h80000000, 1'b1, 1'b1,
        '{32'h7fffffff, 1'b0, 1'b1, ST_M, ST_I}},
      '{OP_READ_EXCL,  1'b0, 8'd255, 32'h0,        32'h80000000, 1'b1, 1'b1,
        '{32'h80000000, 1'b1, 1'b1, ST_M, ST_I}},
      '{OP_WRITE_BACK, 1'b0, 8'd255, 32'hffffffff, 32'h0,        1'b1, 1'b1,
        '{32'hffffffff, 1'b0, 1'b0, ST_I, ST_I}},
      '{OP_UPGRADE,    1'b0, 8'd1,   32'h0,        32'h0,        1'b0, 1'b1,
        '{32'h0,        1'b0, 1'b0, ST_M, ST_I}},
      '{OP_BUS_READ,   1'b1, 8'd1,   32'h0,        32'h12345678, 1'b0, 1'b1,
        '{32'h0,        1'b0, 1'b0, ST_S, ST_M}},
      '{OP_WRITE_BACK, 1'b1, 8'd1,   32'h80000000, 32'h0,        1'b0, 1'b1,
        '{32'h80000000, 1'b0, 1'b0, ST_I, ST_I}},
      '{OP_UPGRADE,    1'b1, 8'd2,   32'h0,        32'h0,        1'b1, 1'b1,
        '{32'h0,        1'b0, 1'b1, ST_M, ST_I}},
      '{OP_WRITE_BACK, 1'b0, 8'd2,   32'h7fffffff, 32'h0,        1'b1, 1'b1,
        '{32'h7fffffff, 1'b0, 1'b1, ST_I, ST_I}},
      '{OP_READ_EXCL,  1'b0, 8'd3,   32'h0,        32'h0,        1'b0, 1'b1,
        '{32'h0,        1'b0, 1'b0, ST_M, ST_I}},
      '{OP_READ_EXCL,  1'b1, 8'd3,   32'h0,        32'h11111111, 1'b0, 1'b0, '0},
      '{OP_BUS_READ,   1'b0, 8'd3,   32'h0,        32'ha5a5a5a5, 1'b1, 1'b0, '0},
      '{OP_UPGRADE,    1'b1, 8'd3,   32'h0,        32'h0,        1'b1, 1'b0, '0},
      '{OP_BUS_READ,   1'b0, 8'd3,   32'h0,        32'h33333333, 1'b0, 1'b0, '0},
      '{OP_READ_EXCL,  1'b1, 8'd3,   32'h0,        32'h5a5a5a5a, 1'b1, 1'b0, '0},
      '{OP_WRITE_BACK, 1'b1, 8'd3,   32'h0,        32'h0,        1'b1, 1'b0, '0},
      '{OP_BUS_READ,   1'b1, 8'd0,   32'h0,        32'hdeadbeef, 1'b1, 1'b0, '0},
      '{OP_UPGRADE,    1'b0, 8'd0,   32'h0,        32'h0,        1'b1, 1'b0, '0}
   };

   msi_two_core_coherence_directory dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one bus request to the directory copy and return the reply
   function automatic rsp_item_type resolve_request(input req_item_type rq);
      rsp_item_type r;
      logic         rc;
      logic         pc;
      logic [1:0]   ps;
      int           a;
      rc = rq.requester;
      pc = ~rq.requester;
      a  = int'(rq.addr) % WORDS;
      ps = core_state[a][pc];
      r  = '0;
      case (rq.op)
         OP_UPGRADE: begin
            core_state[a][rc] = ST_M;
            if (rq.peer_active) begin
               core_state[a][pc] = ST_I;
               r.peer_invalidated = 1'b1;
            end
         end
         OP_BUS_READ: begin
            if (core_state[a][rc] == ST_I)
               core_state[a][rc] = ST_S;
            if (rq.peer_active && ps == ST_M) begin
               word_store[a] = rq.flush_data;
               core_state[a][pc] = ST_S;
               r.peer_flushed = 1'b1;
            end
         end
         OP_READ_EXCL: begin
            core_state[a][rc] = ST_M;
            if (rq.peer_active && ps != ST_I) begin
               // a modified peer hands over its value before it is invalidated
               if (ps == ST_M) begin
                  word_store[a] = rq.flush_data;
                  r.peer_flushed = 1'b1;
               end
               core_state[a][pc] = ST_I;
               r.peer_invalidated = 1'b1;
            end
         end
         default: begin
            word_store[a] = rq.write_data;
            if (rq.peer_active && ps != ST_I)
               r.peer_invalidated = 1'b1;
            core_state[a][rc] = ST_I;
            core_state[a][pc] = ST_I;
         end
      endcase
      r.read_data       = word_store[a];
      r.requester_state = core_state[a][rc];
      r.peer_state      = core_state[a][pc];
      return r;
   endfunction

   // offer one item until taken, then record the reply it must give
   task automatic offer_request(input req_item_type rq, input logic has_exp,
                                input rsp_item_type exp);
      rsp_item_type pred;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, rq.peer_active, rq.flush_data, rq.write_data, rq.addr};
      req_tuser  <= {rq.requester, rq.op};
      do @(posedge clock); while (!req_tready);
      pred = resolve_request(rq);
      pending_replies.push_back(has_exp ? exp : pred);
   endtask

   // stimulus: reset, directed rows back to back, then random bursts
   initial begin : request_source
      req_item_type rq;
      int           burst_left;
      int           gap;
      burst_left = 0;
      for (int a = 0; a < WORDS; a++) begin
         word_store[a]    = '0;
         core_state[a][0] = ST_I;
         core_state[a][1] = ST_I;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         rq.op          = dir_rows[i].op;
         rq.requester   = dir_rows[i].requester;
         rq.addr        = dir_rows[i].addr;
         rq.write_data  = dir_rows[i].wdata;
         rq.flush_data  = dir_rows[i].fdata;
         rq.peer_active = dir_rows[i].active;
         offer_request(rq, dir_rows[i].has_exp, dir_rows[i].exp);
      end

      // receiver goes quiet for a long stretch while items keep coming
      hold_req <= 1'b1;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (n < 24) ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         // one pause until the block has drained completely
         if (n == PAUSE_AT && pending_replies.size() != 0) begin
            req_tvalid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
         rq.op        = op_type'($urandom_range(0, 3));
         rq.requester = 1'($urandom_range(0, 1));
         // mostly a few hot words so that state histories build up
         rq.addr = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, WORDS - 1))
                                                : ADDR_W'($urandom_range(0, 7));
         rq.write_data  = $urandom;
         rq.flush_data  = $urandom;
         rq.peer_active = ($urandom_range(0, 3) != 0);
         offer_request(rq, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (n_errors == 0)
         $display("tb_msi_two_core_coherence_directory: done, clean");
      else
         $display("tb_msi_two_core_coherence_directory: done, errors");
      $finish;
   end

   // receiver: one long hold-off on request, otherwise a changing stall pattern
   initial begin : reply_sink
      int  pct;
      int  left;
      logic held;
      pct  = 100;
      left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         if (left == 0) begin
            case ($urandom_range(0, 3))
               0: pct = 100;
               1: pct = 80;
               2: pct = 50;
               default: pct = 25;
            endcase
            left = $urandom_range(16, 80);
         end
         left--;
         rsp_tready <= ($urandom_range(1, 100) <= pct);
      end
   end

   // compare each reply item with the oldest expectation
   always @(posedge clock) begin : reply_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data        = rsp_tdata[31:0];
         got.peer_flushed     = rsp_tdata[32];
         got.peer_invalidated = rsp_tdata[33];
         got.requester_state  = rsp_tdata[35:34];
         got.peer_state       = rsp_tdata[37:36];
         if (pending_replies.size() == 0) begin
            $error("reply item with none expected: %h", rsp_tdata);
            n_errors++;
         end else begin
            want = pending_replies.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, got.read_data);
               n_errors++;
            end
            if (got.peer_flushed !== want.peer_flushed) begin
               $error("peer_flushed: expected %b, got %b",
                      want.peer_flushed, got.peer_flushed);
               n_errors++;
            end
            if (got.peer_invalidated !== want.peer_invalidated) begin
               $error("peer_invalidated: expected %b, got %b",
                      want.peer_invalidated, got.peer_invalidated);
               n_errors++;
            end
            if (got.requester_state !== want.requester_state) begin
               $error("requester_state: expected %0d, got %0d",
                      want.requester_state, got.requester_state);
               n_errors++;
            end
            if (got.peer_state !== want.peer_state) begin
               $error("peer_state: expected %0d, got %0d", want.peer_state, got.peer_state);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_msi_two_core_coherence_directory: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
